// File: hdl/eti_pkg.sv
// eti_pkg: shared constants, codes and control structs of the escape-time unit
// no dependencies; used by the channel interfaces and all eti modules

package eti_pkg;

	// fixed field widths of the item channels and configuration port
	localparam int C_W         = 32;
	localparam int C_FRAC      = 28;
	localparam int COUNT_OUT_W = 16;
	localparam int MODE_W      = 3;
	localparam int ITER_W      = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// defaults of the top-level parameters
	localparam int FRAC_BITS_DEF  = 28;
	localparam int COUNT_BITS_DEF = 16;

	// reset values of the configuration registers
	localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_MODE = 1'b0,
		REG_MAX_ITER = 1'b1
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_MANDEL      = 3'd0,
		MODE_COMPWISE    = 3'd1,
		MODE_HALF_MIX    = 3'd2,
		MODE_COLLAPSE_Y2 = 3'd3,
		MODE_IGNORE_Y2   = 3'd4
	} map_mode_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // take c, clear z and count
		logic update;  // apply one map step, count up
		logic finish;  // capture result into the output register
	} eti_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic escaped;
		logic at_limit;
	} eti_stat_t;

endpackage

// File: hdl/eti_chan_if.sv
// eti_chan_if: valid/ready channels for point items and result items
// depends on eti_pkg for the field widths

interface eti_point_if import eti_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [C_W-1:0]  c_real;
	logic signed [C_W-1:0]  c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface eti_result_if import eti_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [COUNT_OUT_W-1:0]  escape_count;
	logic                    in_set;

	modport source (output valid, output escape_count, output in_set, input ready);
	modport sink   (input valid, input escape_count, input in_set, output ready);
endinterface

// File: hdl/escape_time_iteration.sv
// escape_time_iteration: top level of the escape-time unit
// depends on eti_pkg, eti_chan_if, eti_ctrl and eti_dpath
//
//  channel   dir   handshake       payload
//  point     in    valid / ready   c_real, c_imag  (signed Q4.28)
//  result    out   valid / ready   escape_count, in_set
//  wr_*      in    wr_en only      wr_idx, wr_data (map_mode, max_iter)
//
// each step registers the products of z in the product stage, then runs the escape
// test, limit test and map update; a point escaping after k updates gives its
// result with escape_count k, an in-set point escape_count 0 and in_set high
// one point at a time; point.ready is high while the sequencer is idle
// the result register lets the next point start while a result waits; a
// point that finishes before the previous result is taken holds in evaluation
// asynchronous reset clears the sequencer, output valid, z, count and config

module escape_time_iteration import eti_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	eti_point_if.sink              point,
	eti_result_if.source           result,
	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_idx,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	// command and status between sequencer and datapath
	eti_cmd_t  cmd;
	eti_stat_t stat;

	// sequencer: idle, products, evaluate/update
	eti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath holds config, z, c, count, the product stage and the result item
	eti_dpath #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_data      (wr_data),
		.c_real       (point.c_real),
		.c_imag       (point.c_imag),
		.cmd          (cmd),
		.stat         (stat),
		.escape_count (result.escape_count),
		.in_set       (result.in_set)
	);

endmodule

// File: hdl/eti_ctrl.sv
// eti_ctrl: sequencing state machine and output valid flag
// depends on eti_pkg for the command and status structs

module eti_ctrl import eti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  eti_stat_t stat,
	output eti_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   done;
	logic   out_free;

	assign done      = stat.escaped | stat.at_limit;
	assign out_free  = ~out_valid_q | out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) & in_valid;
		cmd.update = (state_q == ST_EVAL) & ~done;
		cmd.finish = (state_q == ST_EVAL) & done & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (cmd.update || cmd.finish) begin
						state_q <= cmd.update ? ST_MUL : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/eti_dpath.sv
// eti_dpath: z registers, products, escape test, map update and result register
// depends on eti_pkg for codes, widths and the command and status structs

module eti_dpath import eti_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [CFG_IDX_W-1:0]          wr_idx,
	input  logic [CFG_DATA_W-1:0]         wr_data,
	input  logic signed [C_W-1:0]         c_real,
	input  logic signed [C_W-1:0]         c_imag,
	input  eti_cmd_t                      cmd,
	output eti_stat_t                     stat,
	output logic [COUNT_OUT_W-1:0]        escape_count,
	output logic                          in_set
);

	localparam int ZW  = FRAC_BITS + 6;   // z width, Q6.F
	localparam int MW  = FRAC_BITS + 2;   // magnitude of an in-range z component
	localparam int PRW = 2 * MW;          // full product
	localparam int PW  = FRAC_BITS + 4;   // signed truncated product
	localparam int SW  = ZW + 2;          // update sums before saturation
	localparam int LSH = (FRAC_BITS >= C_FRAC) ? FRAC_BITS - C_FRAC : 0;
	localparam int RSH = (FRAC_BITS <  C_FRAC) ? C_FRAC - FRAC_BITS : 0;
	localparam int CEW = C_W + LSH;
	localparam int LW  = (COUNT_BITS > ITER_W) ? COUNT_BITS : ITER_W;

	localparam logic signed [ZW-1:0] TWO =
		{{(ZW-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
	localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
	localparam logic signed [PW:0] FOUR = {2'b00, 1'b1, {(FRAC_BITS+2){1'b0}}};
	localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});

	function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
		logic [SW-ZW:0] hd;
		hd = v[SW-1:ZW-1];
		if ((&hd) || ~(|hd)) return v[ZW-1:0];
		else if (v[SW-1]) return {1'b1, {(ZW-1){1'b0}}};
		else return {1'b0, {(ZW-1){1'b1}}};
	endfunction

	// configuration
	map_mode_t           map_mode_q;
	logic [ITER_W-1:0]   max_iter_q;

	// iteration state
	logic signed [ZW-1:0]   z_re_q, z_im_q, cx_q, cy_q;
	logic [COUNT_BITS-1:0]  count_q;

	// product stage
	logic signed [PW-1:0]   pxx_s1, pyy_s1, pxy_s1;
	logic                   oob_s1;

	logic signed [CEW-1:0]  cr_ext, ci_ext;
	logic signed [ZW-1:0]   cx_new, cy_new;
	logic [ZW-1:0]          ax, ay;
	logic [MW-1:0]          mag_x, mag_y;
	logic [PRW-1:0]         prod_xx, prod_yy, prod_xy, sh_xx, sh_yy, sh_xy;
	logic signed [PW-1:0]   pos_xy;
	logic                   oob;

	logic signed [PW:0]     mag_sum;
	logic [LW-1:0]          limit;
	logic signed [SW-1:0]   xx, yy, xy, x_e, cx_e, cy_e;
	logic signed [ZW-1:0]   nr, ni;

	// align c from Q4.28 to Q4.F
	always_comb begin
		cr_ext = (CEW'(c_real) <<< LSH) >>> RSH;
		ci_ext = (CEW'(c_imag) <<< LSH) >>> RSH;
		cx_new = ZW'(cr_ext);
		cy_new = ZW'(ci_ext);
	end

	// magnitudes are only meaningful when z lies within the radius-2 box
	always_comb begin
		oob     = (z_re_q > TWO) || (z_re_q < NEG_TWO) ||
			(z_im_q > TWO) || (z_im_q < NEG_TWO);
		ax      = z_re_q[ZW-1] ? -z_re_q : z_re_q;
		ay      = z_im_q[ZW-1] ? -z_im_q : z_im_q;
		mag_x   = ax[MW-1:0];
		mag_y   = ay[MW-1:0];
		prod_xx = PRW'(mag_x) * PRW'(mag_x);
		prod_yy = PRW'(mag_y) * PRW'(mag_y);
		prod_xy = PRW'(mag_x) * PRW'(mag_y);
		sh_xx   = prod_xx >> FRAC_BITS;
		sh_yy   = prod_yy >> FRAC_BITS;
		sh_xy   = prod_xy >> FRAC_BITS;
		pos_xy  = {1'b0, sh_xy[PW-2:0]};
	end

	always_ff @(posedge clk) begin
		oob_s1 <= oob;
		pxx_s1 <= {1'b0, sh_xx[PW-2:0]};
		pyy_s1 <= {1'b0, sh_yy[PW-2:0]};
		pxy_s1 <= (z_re_q[ZW-1] ^ z_im_q[ZW-1]) ? -pos_xy : pos_xy;
	end

	// escape and limit tests
	always_comb begin
		mag_sum       = (PW+1)'(pxx_s1) + (PW+1)'(pyy_s1);
		limit         = (LW'(max_iter_q) > CMAX) ? CMAX : LW'(max_iter_q);
		stat.escaped  = oob_s1 || (mag_sum > FOUR);
		stat.at_limit = LW'(count_q) >= limit;
	end

	// next z under the selected map
	always_comb begin
		xx   = SW'(pxx_s1);
		yy   = SW'(pyy_s1);
		xy   = SW'(pxy_s1);
		x_e  = SW'(z_re_q);
		cx_e = SW'(cx_q);
		cy_e = SW'(cy_q);
		case (map_mode_q)
			MODE_COMPWISE: begin
				ni = (z_im_q == '0) ? cy_q : sat_z(yy);
				nr = (z_re_q == '0) ? cx_q : sat_z(xx);
			end
			MODE_HALF_MIX: begin
				if (count_q == '0) begin
					ni = cy_q;
					nr = cx_q;
				end else begin
					// x uses the freshly saturated y
					ni = sat_z(yy + (x_e >>> 1));
					nr = sat_z(xx + (SW'(ni) >>> 1));
				end
			end
			MODE_COLLAPSE_Y2: begin
				nr = sat_z(xx + cx_e);
				ni = sat_z(xy + xy + yy + cy_e);
			end
			MODE_IGNORE_Y2: begin
				nr = sat_z(xx + cx_e);
				ni = sat_z(xy + xy + cy_e);
			end
			default: begin
				nr = sat_z(xx - yy + cx_e);
				ni = sat_z(xy + xy + cy_e);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q <= MODE_MANDEL;
			max_iter_q <= MAX_ITER_RST;
			z_re_q     <= '0;
			z_im_q     <= '0;
			count_q    <= '0;
		end else begin
			if (wr_en) begin
				case (wr_idx)
					REG_MAP_MODE: map_mode_q <= map_mode_t'(wr_data[MODE_W-1:0]);
					REG_MAX_ITER: max_iter_q <= wr_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				z_re_q  <= '0;
				z_im_q  <= '0;
				count_q <= '0;
			end else if (cmd.update) begin
				z_re_q  <= nr;
				z_im_q  <= ni;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= cx_new;
			cy_q <= cy_new;
		end
		if (cmd.finish) begin
			escape_count <= stat.escaped ? COUNT_OUT_W'(count_q) : '0;
			in_set       <= ~stat.escaped;
		end
	end

endmodule

// File: verif/tb.sv
// tb: self-checking testbench of the escape-time unit escape_time_iteration
// depends on eti_pkg, eti_chan_if and the escape_time_iteration rtl
// runs directed and random points under every map and compares each result

module tb import eti_pkg::*; ();

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	// settling wait after the last expected result is taken
	localparam int SETTLE_CYCLES = 8;
	// longest quiet stretch is an in-set point at max_iter 65535 plus
	// receiver stalls; the limit leaves a wide margin over it
	localparam int unsigned QUIET_LIMIT = 500_000;

	// fixed-point layout of the predictor, default parameters of the block
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int Z_W  = FRAC + 6;
	localparam longint Z_MAX = (longint'(1) <<< (Z_W - 1)) - 1;
	localparam longint Z_MIN = -Z_MAX - 1;
	localparam longint Z_TWO  = longint'(2) <<< FRAC;
	localparam longint Z_FOUR = longint'(2 * 2) <<< FRAC;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;

	// point coordinates in Q4.28
	localparam int Q_ONE = 1 << C_FRAC;
	localparam int unsigned NEAR_SPAN = 9 << (C_FRAC - 2);
	localparam logic signed [C_W-1:0] C_MOST  = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] C_LEAST = {1'b1, {(C_W-1){1'b0}}};

	// map codes past the named ones fall back to the plain map
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

	typedef logic signed [Z_W-1:0] zval_t;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] count;
		logic                   in_set;
	} escape_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_idx;
	logic [CFG_DATA_W-1:0] wr_data;

	eti_point_if  point_ch ();
	eti_result_if result_ch ();

	escape_time_iteration dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.point   (point_ch),
		.result  (result_ch),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predictor copy of the registers and the iteration state
	logic [MODE_W-1:0]         cur_mode;
	logic [ITER_W-1:0]         cur_max_iter;
	zval_t                     z_re;
	zval_t                     z_im;
	logic [COUNT_BITS_DEF-1:0] step_cnt;

	escape_t     pending_escapes[$];
	int unsigned mismatches;

	// idling and hold-off controls shared by the sender and the receiver
	bit          idle_on;
	int unsigned hold_len;
	int unsigned hold_seq;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned quiet_cycles;

	// ---------------------------------------------------------------
	// fixed-point helpers of the predictor
	// ---------------------------------------------------------------

	// product of two z values, magnitude truncated to FRAC fraction bits
	function automatic longint qmul(longint a, longint b);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] prod;
		longint       mag;
		ma   = (a < 0) ? -a : a;
		mb   = (b < 0) ? -b : b;
		prod = {64'd0, ma} * {64'd0, mb};
		mag  = longint'(prod[FRAC +: 64]);
		return ((a < 0) != (b < 0)) ? -mag : mag;
	endfunction

	function automatic zval_t zsat(longint v);
		if (v > Z_MAX)
			return zval_t'(Z_MAX);
		if (v < Z_MIN)
			return zval_t'(Z_MIN);
		return zval_t'(v);
	endfunction

	// Q4.28 point coordinate onto the z fraction grid, floor when narrowing
	function automatic longint align_c(logic signed [C_W-1:0] c);
		if (FRAC >= C_FRAC)
			return longint'(c) <<< (FRAC - C_FRAC);
		return longint'(c) >>> (C_FRAC - FRAC);
	endfunction

	function automatic bit z_escaped(longint x, longint y);
		if (x > Z_TWO || x < -Z_TWO || y > Z_TWO || y < -Z_TWO)
			return 1'b1;
		return (qmul(x, x) + qmul(y, y)) > Z_FOUR;
	endfunction

	// full escape-time run of one point under the current registers
	function automatic escape_t escape_time(logic signed [C_W-1:0] cr,
			logic signed [C_W-1:0] ci);
		longint      cx;
		longint      cy;
		longint      x;
		longint      y;
		longint      xx;
		longint      yy;
		longint      xy;
		int unsigned lim;
		bit          done;
		escape_t     res;
		cx   = align_c(cr);
		cy   = align_c(ci);
		lim  = (cur_max_iter > COUNT_MAX) ? int'(COUNT_MAX) : cur_max_iter;
		z_re = '0;
		z_im = '0;
		step_cnt = '0;
		done = 1'b0;
		res  = '0;
		while (!done) begin
			x = z_re;
			y = z_im;
			// escape test first, so an escape on the last step keeps its count
			if (z_escaped(x, y)) begin
				res.count  = COUNT_OUT_W'(step_cnt);
				res.in_set = 1'b0;
				done = 1'b1;
			end else if (step_cnt >= lim) begin
				res.count  = '0;
				res.in_set = 1'b1;
				done = 1'b1;
			end else begin
				xx = qmul(x, x);
				yy = qmul(y, y);
				xy = qmul(x, y);
				case (cur_mode)
					MODE_COMPWISE: begin
						z_im = zsat((y == 0) ? cy : yy);
						z_re = zsat((x == 0) ? cx : xx);
					end
					MODE_HALF_MIX: begin
						// first step loads c, later x uses the new y
						if (step_cnt == 0) begin
							z_im = zsat(cy);
							z_re = zsat(cx);
						end else begin
							z_im = zsat(yy + (x >>> 1));
							z_re = zsat(xx + (longint'(z_im) >>> 1));
						end
					end
					MODE_COLLAPSE_Y2: begin
						z_re = zsat(xx + cx);
						z_im = zsat(xy + xy + yy + cy);
					end
					MODE_IGNORE_Y2: begin
						z_re = zsat(xx + cx);
						z_im = zsat(xy + xy + cy);
					end
					default: begin
						z_re = zsat(xx - yy + cx);
						z_im = zsat(xy + xy + cy);
					end
				endcase
				step_cnt++;
			end
		end
		return res;
	endfunction

	// mostly points around the sets of interest, some over the full range
	function automatic logic signed [C_W-1:0] rand_coord();
		if ($urandom_range(0, 4) == 0)
			return $urandom();
		return C_W'(int'($urandom_range(0, 2 * NEAR_SPAN)) - int'(NEAR_SPAN));
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_escape(logic [COUNT_OUT_W-1:0] got_count, logic got_in_set);
		escape_t want;
		if (pending_escapes.size() == 0) begin
			report_mismatch("result with no point pending", got_count, 0);
		end else begin
			want = pending_escapes.pop_front();
			if (got_count !== want.count)
				report_mismatch("escape_count", got_count, want.count);
			if (got_in_set !== want.in_set)
				report_mismatch("in_set", got_in_set, want.in_set);
		end
	endtask

	// receiver: checks every taken item, stalls in random bursts and
	// serves the long hold-off that a test asks for
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_escape(result_ch.escape_count, result_ch.in_set);
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0)
			hold_left--;
		else if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 13);
		result_ch.ready <= arst_n && hold_left == 0 && stall_left == 0;
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	// offer one point, maybe after an idle burst; valid stays high on return
	// so back-to-back items need no second assignment in the same step
	task automatic send_point(logic signed [C_W-1:0] cr, logic signed [C_W-1:0] ci);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_ch.valid  <= 1'b1;
		point_ch.c_real <= cr;
		point_ch.c_imag <= ci;
		@(posedge clk);
		while (!point_ch.ready)
			@(posedge clk);
		pending_escapes.push_back(escape_time(cr, ci));
	endtask

	// stop offering and wait for every expected result
	task automatic drain_results();
		point_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_escapes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_MAP_MODE: cur_mode = data[MODE_W-1:0];
			REG_MAX_ITER: cur_max_iter = data[ITER_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// registers only change with the block idle
	task automatic set_config(logic [MODE_W-1:0] mode, logic [ITER_W-1:0] iters);
		drain_results();
		write_reg(REG_MAP_MODE, CFG_DATA_W'(mode));
		write_reg(REG_MAX_ITER, CFG_DATA_W'(iters));
	endtask

	// reset registers: plain map, limit 255, field extremes and boundaries
	task automatic test_reset_defaults();
		send_point(0, 0);
		send_point(C_LEAST, C_LEAST);
		send_point(C_MOST, C_MOST);
		send_point(C_LEAST, C_MOST);
		send_point(C_MOST, C_LEAST);
		// z goes to -2 and then sits at 2 for ever: on the radius, never past it
		send_point(-2 * Q_ONE, 0);
		// z lands exactly on radius 2, escapes one step later
		send_point(2 * Q_ONE, 0);
		// cusp, slow convergence
		send_point(Q_ONE / 4, 0);
		send_point(-3 * Q_ONE / 4, Q_ONE / 10);
	endtask

	// zero limit, a single step and the widest limit
	task automatic test_limit_extremes();
		set_config(MODE_MANDEL, 0);
		send_point(Q_ONE / 2, Q_ONE / 2);
		set_config(MODE_MANDEL, 1);
		// escape on the last allowed step reports the limit
		send_point(C_MOST, 0);
		send_point(0, 0);
		set_config(MODE_MANDEL, {ITER_W{1'b1}});
		send_point(0, 0);
		send_point(-3 * Q_ONE / 4, Q_ONE / 10);
	endtask

	// every other map, spare codes included
	task automatic test_map_modes();
		for (int m = MODE_COMPWISE; m <= MODE_SPARE_LAST; m++) begin
			set_config(MODE_W'(m), 24);
			send_point(Q_ONE / 4, Q_ONE / 2);
			// zero imaginary part keeps the per-component seed path busy
			if (m < MODE_SPARE_FIRST)
				send_point(-3 * Q_ONE / 2, 0);
		end
	endtask

	// long receiver hold-off while points keep coming, so input stalls
	task automatic test_backpressure();
		set_config(MODE_MANDEL, 8);
		hold_len = 400;
		hold_seq++;
		for (int i = 0; i < 6; i++)
			send_point(rand_coord(), rand_coord());
		drain_results();
	endtask

	task automatic test_random_points(int unsigned phases, int unsigned per_phase);
		logic [MODE_W-1:0] mode;
		logic [ITER_W-1:0] iters;
		for (int p = 0; p < phases; p++) begin
			mode = MODE_W'($urandom_range(0, MODE_SPARE_LAST));
			case (p)
				0:       iters = 1;
				1:       iters = 255;
				default: iters = ITER_W'($urandom_range(2, 48));
			endcase
			set_config(mode, iters);
			for (int i = 0; i < per_phase; i++) begin
				send_point(rand_coord(), rand_coord());
				// sender pause mid-phase until everything is back
				if (i == per_phase / 2 && p % 3 == 0)
					drain_results();
			end
		end
	endtask

	// closing stretch with no idling on either side
	task automatic test_steady_stream();
		set_config(MODE_MANDEL, 32);
		idle_on = 1'b0;
		for (int i = 0; i < 100; i++)
			send_point(rand_coord(), rand_coord());
	endtask

	initial begin
		arst_n           = 1'b0;
		point_ch.valid   = 1'b0;
		point_ch.c_real  = '0;
		point_ch.c_imag  = '0;
		result_ch.ready  = 1'b0;
		wr_en            = 1'b0;
		wr_idx           = REG_MAP_MODE;
		wr_data          = '0;
		cur_mode         = MODE_MANDEL;
		cur_max_iter     = MAX_ITER_RST;
		z_re             = '0;
		z_im             = '0;
		step_cnt         = '0;
		mismatches       = 0;
		idle_on          = 1'b1;
		hold_len         = 0;
		hold_seq         = 0;
		hold_seen        = 0;
		hold_left        = 0;
		stall_left       = 0;
		quiet_cycles     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_limit_extremes();
		test_map_modes();
		test_backpressure();
		test_random_points(8, 85);
		test_steady_stream();
		drain_results();

		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hdl/eti_pkg.sv
hdl/eti_chan_if.sv
hdl/eti_ctrl.sv
hdl/eti_dpath.sv
hdl/escape_time_iteration.sv
verif/tb.sv
